[src/rsput_pkg.sv]
// Shared types and constants for the range-sum / point-update tree.
// Used by rsput_ctrl, rsput_dp and the top level; no dependencies.
`default_nettype none

package rsput_pkg;

	localparam int IDX_W = 10;   // index field width
	localparam int LEN_W = 11;   // active_length register width
	localparam int VAL_W = 32;   // value and sum width

	typedef enum logic {
		OP_SET = 1'b0,
		OP_SUM = 1'b1
	} op_t;

	typedef enum logic {
		ST_OK     = 1'b0,
		ST_REJECT = 1'b1
	} status_code_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture accepted transaction, seed pointers
		logic clr_step;   // write one zero during the post-reset sweep
		logic set_rd;     // read node on the update path
		logic set_wr;     // write node on the update path, step up
		logic q_left;     // query: left boundary step
		logic q_right;    // query: right boundary step, move up a level
		logic res_load;   // load the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_done;   // last entry of the sweep being written
		logic item_ok;    // captured transaction passes the range check
		logic is_query;   // captured transaction is a range sum
		logic path_done;  // update has reached the root
		logic span_empty; // query boundaries have met
	} stat_t;

endpackage

`default_nettype wire

[src/rsput_dp.sv]
// Datapath: node memory, update/query pointers, accumulator, output register.
// Depends on rsput_pkg; driven by rsput_ctrl.
`default_nettype none

module rsput_dp #(
	parameter int MAX_POSITIONS = 1024
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wr_en,
	input  wire  [rsput_pkg::LEN_W-1:0]    cfg_wr_data,
	input  wire                            operation,
	input  wire  [rsput_pkg::IDX_W-1:0]    first_index,
	input  wire  [rsput_pkg::IDX_W-1:0]    last_index,
	input  wire  [rsput_pkg::VAL_W-1:0]    new_value,
	input  wire  rsput_pkg::cmd_t          cmd,
	output rsput_pkg::stat_t               stat,
	output logic [rsput_pkg::VAL_W-1:0]    range_total,
	output logic                           status
);
	import rsput_pkg::*;

	localparam int DEPTH = 2 * MAX_POSITIONS;          // heap slots, slot 0 unused
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = AW + 1;                     // pointer may reach DEPTH
	localparam int LW    = ($clog2(MAX_POSITIONS + 1) > LEN_W) ?
	                       $clog2(MAX_POSITIONS + 1) : LEN_W;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rd_data_q;

	logic [LEN_W-1:0] act_len_q;
	op_t              op_q;
	logic [IDX_W-1:0] first_q;
	logic [IDX_W-1:0] last_q;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] delta_q;
	logic [VAL_W-1:0] acc_q;
	logic             leaf_q;     // first write on the update path is the leaf
	logic             pend_q;     // registered read data belongs in the sum
	logic [NW-1:0]    node_q;     // update path node
	logic [NW-1:0]    lo_q;
	logic [NW-1:0]    hi_q;       // exclusive
	logic [AW-1:0]    clr_cnt_q;

	logic [LW-1:0]    len_eff;
	logic [LW-1:0]    first_x;
	logic [LW-1:0]    last_x;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic [NW-1:0]    hi_m1;
	logic             take_lo;
	logic             take_hi;

	// length register; values past the tree size act as the full size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_len_q <= LEN_W'(1024);
		end else if (cfg_wr_en) begin
			act_len_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (LW'(act_len_q) > LW'(MAX_POSITIONS)) begin
			len_eff = LW'(MAX_POSITIONS);
		end else begin
			len_eff = LW'(act_len_q);
		end
		first_x = LW'(first_q);
		last_x  = LW'(last_q);
	end

	assign stat.is_query   = (op_q == OP_SUM);
	assign stat.item_ok    = (op_q == OP_SUM) ? ((last_x < len_eff) && (first_q <= last_q))
	                                          : (first_x < len_eff);
	assign stat.path_done  = (node_q[NW-1:1] == '0);
	assign stat.span_empty = (lo_q >= hi_q);
	assign stat.clr_done   = (clr_cnt_q == AW'(DEPTH - 1));

	assign hi_m1   = hi_q - NW'(1);
	assign take_lo = cmd.q_left & lo_q[0];
	assign take_hi = cmd.q_right & hi_q[0];

	// memory port muxes
	always_comb begin
		rd_en   = cmd.set_rd | take_lo | take_hi;
		rd_addr = node_q[AW-1:0];
		if (cmd.q_left) begin
			rd_addr = lo_q[AW-1:0];
		end else if (cmd.q_right) begin
			rd_addr = hi_m1[AW-1:0];
		end
		wr_en   = cmd.clr_step | cmd.set_wr;
		wr_addr = cmd.clr_step ? clr_cnt_q : node_q[AW-1:0];
		if (cmd.clr_step) begin
			wr_data = '0;
		end else if (leaf_q) begin
			wr_data = value_q;
		end else begin
			wr_data = rd_data_q + delta_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			pend_q <= take_lo | take_hi;
		end
	end

	// item capture, pointers, accumulator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(operation);
			first_q <= first_index;
			last_q  <= last_index;
			value_q <= new_value;
			node_q  <= NW'(first_index) + NW'(MAX_POSITIONS);
			lo_q    <= NW'(first_index) + NW'(MAX_POSITIONS);
			hi_q    <= NW'(last_index) + NW'(MAX_POSITIONS + 1);
			leaf_q  <= 1'b1;
			acc_q   <= '0;
		end else begin
			if (cmd.set_wr) begin
				if (leaf_q) begin
					delta_q <= value_q - rd_data_q;
				end
				leaf_q <= 1'b0;
				node_q <= node_q >> 1;
			end
			if (cmd.q_left) begin
				lo_q <= lo_q + NW'(lo_q[0]);
			end
			if (cmd.q_right) begin
				lo_q <= lo_q >> 1;
				hi_q <= hi_q >> 1;
			end
			if (pend_q) begin
				acc_q <= acc_q + rd_data_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			range_total <= (stat.item_ok && stat.is_query) ? acc_q : '0;
			status      <= stat.item_ok ? ST_OK : ST_REJECT;
		end
	end

endmodule

`default_nettype wire

[src/rsput_ctrl.sv]
// Sequencer for the tree: clear sweep, update path walk, query boundary walk.
// Depends on rsput_pkg; commands rsput_dp.
`default_nettype none

module rsput_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire                    out_ready,
	input  wire rsput_pkg::stat_t  stat,
	output rsput_pkg::cmd_t        cmd
);
	import rsput_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_SET_RD = 8'b0000_1000,
		S_SET_WR = 8'b0001_0000,
		S_Q_L    = 8'b0010_0000,
		S_Q_R    = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!stat.item_ok) begin
					state_d = S_DONE;
				end else if (stat.is_query) begin
					state_d = S_Q_L;
				end else begin
					state_d = S_SET_RD;
				end
			end
			S_SET_RD: begin
				cmd.set_rd = 1'b1;
				state_d    = S_SET_WR;
			end
			S_SET_WR: begin
				cmd.set_wr = 1'b1;
				state_d    = stat.path_done ? S_DONE : S_SET_RD;
			end
			S_Q_L: begin
				if (stat.span_empty) begin
					state_d = S_DONE;
				end else begin
					cmd.q_left = 1'b1;
					state_d    = S_Q_R;
				end
			end
			S_Q_R: begin
				cmd.q_right = 1'b1;
				state_d     = S_Q_L;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[src/range_sum_point_update_tree.sv]
// Range-sum / point-update tree, top level. Uses rsput_pkg, rsput_ctrl, rsput_dp.
// Sequence: a set goes through CHECK, then SET_RD and SET_WR once per tree level,
// then DONE; a query alternates Q_L and Q_R, one pair per level, until its bounds
// meet; a rejected item goes from CHECK straight to DONE. One transaction at a time,
// next one taken the cycle after the result is registered.
// Reset: async; then a zeroing sweep over all 2*MAX_POSITIONS slots with in_ready low.
`default_nettype none

module range_sum_point_update_tree #(
	parameter int MAX_POSITIONS = 1024
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// configuration: active_length
	input  wire                                 cfg_wr_en,
	input  wire        [rsput_pkg::LEN_W-1:0]   cfg_wr_data,
	// input transactions
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  wire                                 operation,
	input  wire        [rsput_pkg::IDX_W-1:0]   first_index,
	input  wire        [rsput_pkg::IDX_W-1:0]   last_index,
	input  wire signed [rsput_pkg::VAL_W-1:0]   new_value,
	// result transactions
	output logic                                out_valid,
	input  wire                                 out_ready,
	output logic signed [rsput_pkg::VAL_W-1:0]  range_total,
	output logic                                status
);
	import rsput_pkg::*;

	// Storage is an implicit heap of 2*MAX_POSITIONS sums: slot MAX_POSITIONS+i
	// is position i, slot k holds slots 2k and 2k+1. Any size works, not only
	// powers of two, since only sums (commutative) are combined.
	// A set reads the leaf, forms delta = new - old, and walks up adding delta.
	// A query walks half-open bounds [lo, hi) upward, picking up odd edge slots.

	cmd_t             cmd;
	stat_t            stat;
	logic [VAL_W-1:0] total_raw;

	rsput_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rsput_dp #(
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.operation   (operation),
		.first_index (first_index),
		.last_index  (last_index),
		.new_value   (new_value),
		.cmd         (cmd),
		.stat        (stat),
		.range_total (total_raw),
		.status      (status)
	);

	// result payload register lives in the datapath; out_valid in the controller
	assign range_total = total_raw;

endmodule

`default_nettype wire

[src/rsput_checker.sv]
// Port-level checks for range_sum_point_update_tree, attached by bind below.
// Depends on rsput_pkg for field widths.
`default_nettype none

module rsput_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_ready,
	input wire                          out_valid,
	input wire                          out_ready,
	input wire [rsput_pkg::VAL_W-1:0]   range_total,
	input wire                          status
);
	import rsput_pkg::*;

	// one transaction in flight: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after an accept");

	// no result can appear the cycle right after an accept
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$rose(out_valid))
		else $error("result too early after accept");

	// rejected items carry a zero sum
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_REJECT) |-> (range_total == '0))
		else $error("rejected transaction with nonzero total");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(range_total) && $stable(status)))
		else $error("result changed while stalled");

endmodule

bind range_sum_point_update_tree rsput_checker u_rsput_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.range_total (range_total),
	.status      (status)
);

`default_nettype wire

[bench/range_sum_point_update_tree_tb.sv]
// Self-checking bench for range_sum_point_update_tree: directed and random sets and range sums.
// Depends on rsput_pkg and the RTL under src; a shadow array predicts every reply.
`timescale 1ns / 100ps

module range_sum_point_update_tree_tb;

	import rsput_pkg::*;

	localparam int MAX_POSITIONS = 1024;
	localparam int HOLD_CYCLES   = 400;   // long receiver hold-off for the pressure test

	// one owed reply per accepted request
	typedef struct {
		logic signed [VAL_W-1:0] total;
		status_code_t            code;
	} reply_t;

	// Shadow of the stored array. The tree always spans every position, so a range
	// sum is just the wrapped sum of the shadow values; active_length only gates.
	class range_sum_shadow;
		logic signed [VAL_W-1:0] shadow_values [MAX_POSITIONS];
		int unsigned             length_reg;
		reply_t                  owed_replies [$];
		int unsigned             errors;

		function new();
			foreach (shadow_values[i]) shadow_values[i] = '0;
			length_reg = MAX_POSITIONS;
			errors = 0;
		endfunction

		function void set_length(logic [LEN_W-1:0] len);
			length_reg = len;
		endfunction

		// lengths above the array size behave as the full array
		function int unsigned limit();
			return (length_reg > MAX_POSITIONS) ? MAX_POSITIONS : length_reg;
		endfunction

		function int unsigned pending();
			return owed_replies.size();
		endfunction

		function void log_request(op_t op, logic [IDX_W-1:0] first, logic [IDX_W-1:0] last,
				logic signed [VAL_W-1:0] value);
			reply_t      r;
			int unsigned lim;
			int          i;
			lim = limit();
			r.total = '0;
			r.code = ST_OK;
			if (op == OP_SET) begin
				// a rejected set leaves the array untouched
				if (first >= lim) r.code = ST_REJECT;
				else shadow_values[first] = value;
			end else if (last >= lim || first > last) begin
				r.code = ST_REJECT;
			end else begin
				for (i = first; i <= last; i++) r.total += shadow_values[i];
			end
			owed_replies = {owed_replies, r};
		endfunction

		task report(string what);
			$display("MISMATCH @%0t: %s", $time, what);
			errors++;
		endtask

		task check_reply(logic signed [VAL_W-1:0] total, logic code);
			reply_t r;
			if (owed_replies.size() == 0) begin
				report($sformatf("reply total=%0d status=%0d with nothing owed", total, code));
			end else begin
				r = owed_replies.pop_front();
				if (total !== r.total)
					report($sformatf("range_total %0d, predicted %0d", total, r.total));
				if (code !== r.code)
					report($sformatf("status %0d, predicted %0d", code, r.code));
			end
		endtask
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	logic [LEN_W-1:0]        cfg_wr_data;
	logic                    in_valid;
	logic                    in_ready;
	logic                    operation;
	logic [IDX_W-1:0]        first_index;
	logic [IDX_W-1:0]        last_index;
	logic signed [VAL_W-1:0] new_value;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [VAL_W-1:0] range_total;
	logic                    status;

	range_sum_shadow book = new();

	// pacing knobs; the two _pct knobs are in percent of cycles
	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	bit          hold_req  = 1'b0;
	bit          hold_out  = 1'b0;

	range_sum_point_update_tree #(
		.MAX_POSITIONS(MAX_POSITIONS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.first_index (first_index),
		.last_index  (last_index),
		.new_value   (new_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.range_total (range_total),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop: far beyond the slowest legal run (sweep, ~1350 transactions, stalls)
	initial begin
		#6_400_000;
		$display("range_sum_point_update_tree_tb: done, errors");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off counted here in cycles.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= hold_out ? 1'b0 : ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		wait (hold_req);
		hold_out = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_out = 1'b0;
	end

	// every accepted result transaction is checked against the oldest owed reply
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_reply(range_total, status);
	end

	// Offer one request. Valid stays high after acceptance; the next call either
	// replaces the payload or drops valid for an idle cycle at the next falling edge.
	task automatic send_item(op_t op, logic [IDX_W-1:0] first, logic [IDX_W-1:0] last,
			logic signed [VAL_W-1:0] value);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		operation   <= op;
		first_index <= first;
		last_index  <= last;
		new_value   <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		book.log_request(op, first, last, value);
	endtask

	// drop valid and wait for every owed reply; the block is then idle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
	endtask

	task automatic write_length(logic [LEN_W-1:0] len);
		drain();
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= len;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		book.set_length(len);
	endtask

	// Mostly well-formed requests inside the active length, with a hot window of
	// low positions so sets overwrite earlier values; the rest is raw noise.
	task automatic send_random(int unsigned count);
		op_t                     op;
		logic [IDX_W-1:0]        first;
		logic [IDX_W-1:0]        last;
		logic signed [VAL_W-1:0] value;
		int unsigned             lim;
		int unsigned             span;
		repeat (count) begin
			lim   = book.limit();
			op    = op_t'($urandom_range(1));
			first = IDX_W'($urandom);
			last  = IDX_W'($urandom);
			if (lim > 0 && $urandom_range(99) < 85) begin
				span  = ($urandom_range(3) == 0 && lim > 16) ? 16 : lim;
				first = IDX_W'($urandom_range(span - 1));
				if (op == OP_SUM) last = IDX_W'($urandom_range(lim - 1, first));
			end
			case ($urandom_range(7))
				0: value = 32'h7FFF_FFFF;
				1: value = 32'h8000_0000;
				2: value = $urandom_range(15) - 8;
				default: value = $urandom;
			endcase
			send_item(op, first, last, value);
		end
	endtask

	task automatic run_phase(logic [LEN_W-1:0] len, int unsigned idle, int unsigned stall,
			int unsigned count);
		write_length(len);
		idle_pct  = idle;
		stall_pct = stall;
		send_random(count);
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		operation   = 1'b0;
		first_index = '0;
		last_index  = '0;
		new_value   = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: full length from reset. Value extremes at both array ends,
		// a wrapping full-range sum, an overwrite, reversed range.
		send_item(OP_SET, 10'd0, 10'd1023, 32'h7FFF_FFFF);
		send_item(OP_SET, 10'd1023, 10'd0, 32'h8000_0000);
		send_item(OP_SET, 10'd512, 10'd511, -32'sd1);
		send_item(OP_SUM, 10'd0, 10'd1023, $urandom);
		send_item(OP_SUM, 10'd0, 10'd0, 32'hFFFF_FFFF);
		send_item(OP_SUM, 10'd1023, 10'd1023, 32'h0);
		send_item(OP_SET, 10'd0, 10'd0, 32'h0);
		send_item(OP_SUM, 10'd0, 10'd511, $urandom);
		send_item(OP_SUM, 10'd512, 10'd1023, $urandom);
		send_item(OP_SUM, 10'd7, 10'd3, $urandom);

		// smallest useful length: one position
		write_length(11'd1);
		send_item(OP_SET, 10'd0, 10'd0, 32'sd5);
		send_item(OP_SET, 10'd1, 10'd1, 32'sd9);
		send_item(OP_SUM, 10'd0, 10'd0, $urandom);
		send_item(OP_SUM, 10'd0, 10'd1, $urandom);
		send_item(OP_SUM, 10'd1, 10'd0, $urandom);

		// zero length rejects everything
		write_length(11'd0);
		send_item(OP_SET, 10'd0, 10'd0, 32'sd3);
		send_item(OP_SUM, 10'd0, 10'd0, $urandom);

		// oversized length acts as full; values above the old length survived
		write_length(11'd2047);
		send_item(OP_SUM, 10'd0, 10'd1023, $urandom);
		send_item(OP_SET, 10'd1023, 10'd1000, 32'h1234_5678);
		send_item(OP_SUM, 10'd1000, 10'd1023, $urandom);

		// boundary of a mid length
		write_length(11'd600);
		send_item(OP_SET, 10'd599, 10'd0, -32'sd7);
		send_item(OP_SET, 10'd600, 10'd0, 32'sd11);
		send_item(OP_SUM, 10'd512, 10'd599, $urandom);
		send_item(OP_SUM, 10'd0, 10'd600, $urandom);

		write_length(11'd1024);
		send_item(OP_SUM, 10'd0, 10'd1023, $urandom);

		// Random phases across lengths and pacing modes.
		run_phase(11'd1024, 0, 0, 220);
		run_phase(11'd1024, 57, 0, 190);
		// receiver holds off while requests keep coming
		write_length(11'd1024);
		idle_pct  = 0;
		stall_pct = 57;
		hold_req  = 1'b1;
		send_random(190);
		run_phase(11'd1024, 14, 14, 190);
		run_phase(11'd1, 0, 0, 60);
		run_phase(11'd2047, 57, 0, 190);
		run_phase(11'd300, 0, 57, 190);
		run_phase(11'($urandom_range(1023, 2)), 14, 14, 120);

		drain();
		repeat (40) @(posedge clk);
		if (book.errors == 0) begin
			$display("range_sum_point_update_tree_tb: done, clean");
		end else begin
			$display("range_sum_point_update_tree_tb: done, errors");
		end
		$finish;
	end

endmodule
